>>> sv/float_residual_symbolizer_unit_defines.svh
// Assertion macros shared by the RTL.
`ifndef FLOAT_RESIDUAL_SYMBOLIZER_UNIT_DEFINES_SVH
`define FLOAT_RESIDUAL_SYMBOLIZER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define FRSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define FRSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/frsu_pkg.sv
package frsu_pkg;

  localparam int unsigned SPLIT_BITS_DEF = 12;
  localparam int unsigned MAX_SYMS       = 5;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_LAST   = 2'd1;
  localparam logic [1:0] ACT_ACROSS = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] STREAM_SE   = 2'd0;
  localparam logic [1:0] STREAM_BITS = 2'd1;
  localparam logic [1:0] STREAM_CHI  = 2'd2;
  localparam logic [1:0] STREAM_CLO  = 2'd3;

  localparam logic [1:0] MODEL_CLASS = 2'd0;
  localparam logic [1:0] MODEL_ESC   = 2'd1;
  localparam logic [1:0] MODEL_BITS  = 2'd2;
  localparam logic [1:0] MODEL_CORR  = 2'd3;

  localparam logic [3:0] CLS_SIGN = 4'd0;
  localparam logic [3:0] CLS_SAME = 4'd4;
  localparam logic [3:0] CLS_FAR  = 4'd8;

  localparam logic [12:0] ALPHA_CLASS = 13'd9;
  localparam logic [12:0] ALPHA_ESC   = 13'd256;
  localparam logic [12:0] ALPHA_BITS  = 13'd23;

  typedef struct packed {
    logic [1:0]  coder_set;
    logic [1:0]  stream_id;
    logic [1:0]  model_id;
    logic [7:0]  context_res;
    logic [11:0] symbol;
    logic [12:0] alphabet_size;
  } sym_t;

endpackage

>>> sv/frsu_symbolize.sv
module frsu_symbolize #(
  parameter int unsigned SPLIT_BITS = frsu_pkg::SPLIT_BITS_DEF
) (
  input  logic [1:0]     mode_i,
  input  logic [31:0]    pred_i,
  input  logic [31:0]    act_i,
  output frsu_pkg::sym_t syms_o [frsu_pkg::MAX_SYMS],
  output logic [2:0]     count_o
);

  localparam logic signed [24:0] FOLD_LO   = -25'sd4194303;
  localparam logic signed [24:0] FOLD_HI   = 25'sd4194304;
  localparam logic signed [24:0] FOLD_SPAN = 25'sd8388608;
  localparam logic [23:0] HI_OFS   = 24'((1 << (SPLIT_BITS - 1)) - 1);
  localparam logic [23:0] ALPHA_HW = 24'(1) << SPLIT_BITS;
  localparam logic [7:0]  CTX_HI   = 8'(SPLIT_BITS - 1);
  localparam logic [4:0]  SPLIT_K  = 5'(SPLIT_BITS);

  logic [8:0]         se_p, se_a;
  logic [22:0]        m_p, m_a;
  logic signed [8:0]  d;
  logic [3:0]         cls;
  logic               esc, split;
  logic signed [24:0] c_raw, c_fold;
  logic signed [23:0] c;
  logic [23:0]        mag_w, abs_w, pow_k, sym_s_w, hi_mag, hi_w, alpha_lo_w;
  logic [24:0]        alpha_s_w;
  logic [21:0]        mag;
  logic [4:0]         k, k1;
  logic [23:0]        lo_w;
  frsu_pkg::sym_t     e_cls, e_esc, e_k, e_c1, e_c2;

  assign se_p = pred_i[31:23];
  assign se_a = act_i[31:23];
  assign m_a  = act_i[22:0];
  assign m_p  = (se_p == se_a) ? pred_i[22:0] : 23'd0;

  always_comb begin
    d   = $signed({1'b0, se_a[7:0]}) - $signed({1'b0, se_p[7:0]});
    cls = frsu_pkg::CLS_SIGN;
    if (se_p == se_a) begin
      cls = frsu_pkg::CLS_SAME;
    end else if (se_p[8] == se_a[8]) begin
      if (d >= -9'sd3 && d <= 9'sd3) begin
        cls = 4'(d + 9'sd4);
      end else begin
        cls = frsu_pkg::CLS_FAR;
      end
    end
  end

  assign esc = (cls == frsu_pkg::CLS_SIGN) || (cls == frsu_pkg::CLS_FAR);

  always_comb begin
    c_raw = $signed({2'b00, m_a}) - $signed({2'b00, m_p});
    if (c_raw < FOLD_LO) begin
      c_fold = c_raw + FOLD_SPAN;
    end else if (c_raw > FOLD_HI) begin
      c_fold = c_raw - FOLD_SPAN;
    end else begin
      c_fold = c_raw;
    end
  end

  assign c     = c_fold[23:0];
  assign mag_w = (c <= 24'sd0) ? 24'(-c) : 24'(c - 24'sd1);
  assign mag   = mag_w[21:0];

  always_comb begin
    k = 5'd0;
    for (int i = 0; i < 22; i++) begin
      if (mag[i]) begin
        k = 5'(i + 1);
      end
    end
  end

  assign split = (k >= SPLIT_K);

  assign pow_k     = 24'(1) << k;
  assign sym_s_w   = 24'(c) + pow_k - 24'd1;
  assign alpha_s_w = 25'(1) << (k + 5'd1);

  assign k1         = k - SPLIT_K + 5'd1;
  assign abs_w      = (c < 24'sd0) ? 24'(-c) : 24'(c);
  assign lo_w       = abs_w & ((24'(1) << k1) - 24'd1);
  assign hi_mag     = abs_w >> k1;
  assign hi_w       = ((c < 24'sd0) ? (24'd0 - hi_mag) : hi_mag) + HI_OFS;
  assign alpha_lo_w = 24'(1) << k1;

  always_comb begin
    e_cls = '{coder_set: mode_i, stream_id: frsu_pkg::STREAM_SE,
              model_id: frsu_pkg::MODEL_CLASS, context_res: se_p[7:0],
              symbol: 12'(cls), alphabet_size: frsu_pkg::ALPHA_CLASS};
    e_esc = '{coder_set: mode_i, stream_id: frsu_pkg::STREAM_SE,
              model_id: frsu_pkg::MODEL_ESC, context_res: 8'd0,
              symbol: 12'(se_a[7:0]), alphabet_size: frsu_pkg::ALPHA_ESC};
    e_k   = '{coder_set: mode_i, stream_id: frsu_pkg::STREAM_BITS,
              model_id: frsu_pkg::MODEL_BITS, context_res: se_a[7:0],
              symbol: 12'(k), alphabet_size: frsu_pkg::ALPHA_BITS};
    if (split) begin
      e_c1 = '{coder_set: mode_i, stream_id: frsu_pkg::STREAM_CHI,
               model_id: frsu_pkg::MODEL_CORR, context_res: CTX_HI,
               symbol: hi_w[11:0], alphabet_size: ALPHA_HW[12:0]};
    end else begin
      e_c1 = '{coder_set: mode_i, stream_id: frsu_pkg::STREAM_CHI,
               model_id: frsu_pkg::MODEL_CORR, context_res: 8'(k),
               symbol: sym_s_w[11:0], alphabet_size: alpha_s_w[12:0]};
    end
    e_c2 = '{coder_set: mode_i, stream_id: frsu_pkg::STREAM_CLO,
             model_id: frsu_pkg::MODEL_CORR, context_res: 8'(k),
             symbol: lo_w[11:0], alphabet_size: alpha_lo_w[12:0]};

    syms_o[0] = e_cls;
    if (esc) begin
      syms_o[1] = e_esc;
      syms_o[2] = e_k;
      syms_o[3] = e_c1;
      syms_o[4] = e_c2;
    end else begin
      syms_o[1] = e_k;
      syms_o[2] = e_c1;
      syms_o[3] = e_c2;
      syms_o[4] = e_c2;
    end
    count_o = 3'd3 + 3'(esc) + 3'(split);
  end

endmodule

>>> sv/frsu_out_seq.sv
module frsu_out_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  frsu_pkg::sym_t syms_i [frsu_pkg::MAX_SYMS],
  input  logic [2:0]     count_i,
  output logic           free_o,
  output logic           tvalid_o,
  input  logic           tready_i,
  output frsu_pkg::sym_t sym_o,
  output logic           last_o
);

  frsu_pkg::sym_t buf_q [frsu_pkg::MAX_SYMS];
  logic [2:0]     cnt_q, idx_q;
  logic           vld_q;
  logic           take;

  assign take     = vld_q && tready_i;
  assign last_o   = ((idx_q + 3'd1) == cnt_q);
  assign free_o   = !vld_q || (take && last_o);
  assign tvalid_o = vld_q;
  assign sym_o    = buf_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= 3'd0;
      idx_q <= 3'd0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      cnt_q <= count_i;
      idx_q <= 3'd0;
    end else if (take) begin
      if (last_o) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= syms_i;
    end
  end

endmodule

>>> sv/float_residual_symbolizer_unit.sv
// An item is held in the input register, then loaded into the output sequencer, which offers its
// first beat once free, so the next item can be taken while the last one's beats go out.
// One beat per cycle while m_axis_tready is high on the single result port (class, optional
// escape, bit count, one or two corrector beats). Unused-mode items are dropped and give no beats.
// Reset clears the input and result valid flags and sets the previous value to zero.
`include "float_residual_symbolizer_unit_defines.svh"

module float_residual_symbolizer_unit #(
  parameter int unsigned SPLIT_BITS = frsu_pkg::SPLIT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // predicted_value[31:0], actual_value[63:32]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // context_res[7:0], symbol[19:8], alphabet_size[32:20]
  output logic [5:0]  m_axis_tuser,  // coder_set[1:0], stream_id[3:2], model_id[5:4]
  output logic        m_axis_tlast   // last_of_item
);

  logic           in_valid_q;
  logic [1:0]     in_mode_q;
  logic [31:0]    in_pred_q, in_act_q, prev_q, pred_sel;
  logic           free, adv, load, drop;
  frsu_pkg::sym_t syms [frsu_pkg::MAX_SYMS];
  frsu_pkg::sym_t sym_out;
  logic [2:0]     count;
  logic           corr_beat;

  assign drop          = (in_mode_q == frsu_pkg::ACT_UNUSED);
  assign load          = in_valid_q && !drop && free;
  assign adv           = in_valid_q && (drop || free);
  assign s_axis_tready = !in_valid_q || adv;
  assign pred_sel      = (in_mode_q == frsu_pkg::ACT_NONE) ? prev_q : in_pred_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      prev_q     <= 32'd0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        prev_q <= in_act_q;
      end
    end
  end

  // hold the beat until the next stage frees up or the beat is dropped
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= s_axis_tuser;
      in_pred_q <= s_axis_tdata[31:0];
      in_act_q  <= s_axis_tdata[63:32];
    end
  end

  frsu_symbolize #(
    .SPLIT_BITS (SPLIT_BITS)
  ) u_symbolize (
    .mode_i  (in_mode_q),
    .pred_i  (pred_sel),
    .act_i   (in_act_q),
    .syms_o  (syms),
    .count_o (count)
  );

  frsu_out_seq u_out_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .syms_i   (syms),
    .count_i  (count),
    .free_o   (free),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .sym_o    (sym_out),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, sym_out.alphabet_size, sym_out.symbol, sym_out.context_res};
  assign m_axis_tuser = {sym_out.model_id, sym_out.stream_id, sym_out.coder_set};

  assign corr_beat = (sym_out.stream_id == frsu_pkg::STREAM_CHI) ||
                     (sym_out.stream_id == frsu_pkg::STREAM_CLO);

  `FRSU_ASSERT_IMP(a_last_is_corr, m_axis_tvalid && m_axis_tlast, corr_beat, "last beat is not a corrector")
  `FRSU_ASSERT_NXT(a_prev_tracks, load, prev_q == $past(in_act_q), "previous value not updated")
  `FRSU_ASSERT_IMP(a_stall_held, !s_axis_tready, in_valid_q && !drop, "input stalled without a held item")

endmodule
